// File: rtl/multiboot_upload_encryptor_top_macros.svh
// Assertion macros for the port checker of the multiboot upload encoder.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef MULTIBOOT_UPLOAD_ENCRYPTOR_TOP_MACROS_SVH
`define MULTIBOOT_UPLOAD_ENCRYPTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBENC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbenc port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBENC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbenc port check failed");

`endif

// File: rtl/mbenc_pkg.sv
// Package for the multiboot upload encoder: beat types, constants and CRC helpers.
// Used by mbenc_crypt, the top level and the port checker.
package mbenc_pkg;

    localparam int unsigned MAX_IMAGE_BYTES_DEF = 262144;
    localparam int unsigned OFFSET_W  = 19;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BYTES = 1'b1;

    localparam logic [15:0] CRC_POLY     = 16'ha1c1;
    localparam logic [15:0] CRC_INIT     = 16'h15a0;
    localparam logic [31:0] KEY_MULT     = 32'h6177614B;
    localparam logic [31:0] KEY_ALT      = 32'h6F646573;
    localparam logic [31:0] SESSION_MASK = 32'h7365646F;
    localparam logic [31:0] BODY_XOR     = 32'h20796220;
    localparam logic [31:0] OFFSET_BASE  = 32'h02000000;
    localparam logic [31:0] HS_BASE      = 32'h00380000;
    localparam logic [31:0] HS_MARK      = 32'h80808080;
    localparam logic [OFFSET_W-1:0] HEADER_END = 19'h000C0;
    localparam logic [OFFSET_W-1:0] WORD_BYTES = 19'h00004;
    localparam int unsigned MIN_SEND_BYTES = 512;

    // Two key steps folded into one multiply: k*M*M + M + 1.
    localparam logic [63:0] KEY_MULT_SQ_FULL = 64'(KEY_MULT) * 64'(KEY_MULT);
    localparam logic [31:0] KEY_MULT_SQ  = KEY_MULT_SQ_FULL[31:0];
    localparam logic [31:0] KEY_STEP2_ADD = KEY_MULT + 32'd1;

    typedef enum logic [1:0] {
        KIND_HANDSHAKE = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_BODY      = 2'd2,
        KIND_CRC       = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        is_final_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        kind_t       word_kind;
        logic        end_of_run;
    } out_item_t;

    // Running state carried from one word to the next.
    typedef struct packed {
        logic [15:0]         crc;
        logic [31:0]         key;
        logic [OFFSET_W-1:0] offset;
    } run_state_t;

    // Results of one word: one or two beats.
    typedef struct packed {
        logic      pair;
        out_item_t first_beat;
        out_item_t second_beat;
    } beats_t;

    // Bit-serial CRC over one word; used only to build the column table below.
    function automatic logic [15:0] crc_serial(logic [15:0] c, logic [31:0] v);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int b = 0; b < 32; b++) begin
            fb = r[0] ^ v[b];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // The CRC update is linear: one column per CRC bit, then one per data bit.
    function automatic logic [47:0][15:0] crc_columns();
        logic [47:0][15:0] cols;
        for (int i = 0; i < 16; i++) begin
            cols[i] = crc_serial(16'(1) << i, 32'd0);
        end
        for (int i = 0; i < 32; i++) begin
            cols[16 + i] = crc_serial(16'd0, 32'(1) << i);
        end
        return cols;
    endfunction

    localparam logic [47:0][15:0] CRC_COLS = crc_columns();

    // Word-wide CRC as an XOR of independent columns.
    function automatic logic [15:0] crc_update(logic [15:0] c, logic [31:0] v);
        logic [15:0] acc;
        acc = 16'd0;
        for (int i = 0; i < 16; i++) begin
            if (c[i])
            begin
                acc = acc ^ CRC_COLS[i];
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (v[i])
            begin
                acc = acc ^ CRC_COLS[16 + i];
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] swap32(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Handshake key as it goes on the link, from the send size in bytes.
    function automatic logic [31:0] handshake_word(logic [31:0] size);
        logic [31:0] s;
        logic [31:0] r2;
        logic [7:0]  top;
        logic [31:0] r3;
        s   = (size - 32'(MIN_SEND_BYTES)) >> 3;
        r2  = ((s & 32'h3F80) << 1) | ((s & 32'h4000) << 2) | (s & 32'h7F) | HS_BASE;
        top = r2[15:8] + r2[23:16] + r2[7:0];
        r3  = {top, 24'd0} | r2 | HS_MARK;
        return r3 ^ (r3[9] ? KEY_ALT : KEY_MULT);
    endfunction

endpackage

// File: rtl/mbenc_crypt.sv
// Encoding logic for one image word: CRC, key stepping and beat formation.
// Depends on mbenc_pkg; instantiated by multiboot_upload_encryptor_top.
module mbenc_crypt
    import mbenc_pkg::*;
#(
    parameter int unsigned SIZE_W = 19
) (
    input  in_item_t    item,
    input  run_state_t  state,
    input  logic [31:0] session_key,
    input  logic [SIZE_W-1:0] send_size,
    input  logic [31:0] hs_word,
    output run_state_t  state_next,
    output beats_t      beats
);

    logic        first_word;
    logic        in_header;
    logic [31:0] key_base;
    logic [15:0] crc_base;
    logic [31:0] key_one;
    logic [31:0] key_two;
    logic [15:0] crc_new;
    logic [OFFSET_W-1:0] off_next;
    logic [31:0] main_word;
    logic [31:0] crc_plain;
    logic [31:0] crc_key;
    logic [31:0] crc_enc;
    logic [31:0] off_term;
    logic [31:0] off_term_next;

    // A zero offset starts a run: reload the key from the session word.
    assign first_word = (state.offset == '0);
    assign in_header  = (state.offset < HEADER_END);
    assign key_base   = first_word ? swap32(session_key ^ SESSION_MASK) : state.key;
    assign crc_base   = first_word ? CRC_INIT : state.crc;

    // One and two key steps, computed side by side.
    assign key_one = key_base * KEY_MULT + 32'd1;
    assign key_two = key_base * KEY_MULT_SQ + KEY_STEP2_ADD;

    assign crc_new  = in_header ? crc_base : crc_update(crc_base, item.data_word);
    assign off_next = state.offset + WORD_BYTES;

    // Negated offset terms for this word and for the CRC word after it.
    assign off_term      = 32'd0 - (32'(state.offset) + OFFSET_BASE);
    assign off_term_next = 32'd0 - (32'(off_next) + OFFSET_BASE);

    assign main_word = in_header ? item.data_word
                                 : (item.data_word ^ key_one ^ off_term ^ BODY_XOR);

    // Header words leave the key alone, so the CRC word takes only one step then.
    assign crc_plain = {16'(send_size), crc_new};
    assign crc_key   = in_header ? key_one : key_two;
    assign crc_enc   = crc_plain ^ crc_key ^ off_term_next ^ BODY_XOR;

    // Next run state; the final word restarts the run.
    always_comb
    begin
        if (item.is_final_word)
        begin
            state_next.crc    = CRC_INIT;
            state_next.key    = 32'd0;
            state_next.offset = '0;
        end
        else
        begin
            state_next.crc    = crc_new;
            state_next.key    = in_header ? key_base : key_one;
            state_next.offset = off_next;
        end
    end

    // Beat formation: handshake first on a new run, CRC last on a final word that does not open a run.
    always_comb
    begin
        beats = '0;
        if (first_word)
        begin
            beats.pair                   = 1'b1;
            beats.first_beat.out_word    = hs_word;
            beats.first_beat.word_kind   = KIND_HANDSHAKE;
            beats.first_beat.end_of_run  = 1'b0;
            beats.second_beat.out_word   = main_word;
            beats.second_beat.word_kind  = KIND_HEADER;
            beats.second_beat.end_of_run = 1'b1;
        end
        else if (item.is_final_word)
        begin
            beats.pair                   = 1'b1;
            beats.first_beat.out_word    = main_word;
            beats.first_beat.word_kind   = in_header ? KIND_HEADER : KIND_BODY;
            beats.first_beat.end_of_run  = 1'b0;
            beats.second_beat.out_word   = crc_enc;
            beats.second_beat.word_kind  = KIND_CRC;
            beats.second_beat.end_of_run = 1'b1;
        end
        else
        begin
            beats.pair                  = 1'b0;
            beats.first_beat.out_word   = main_word;
            beats.first_beat.word_kind  = in_header ? KIND_HEADER : KIND_BODY;
            beats.first_beat.end_of_run = 1'b1;
        end
    end

endmodule

// File: rtl/multiboot_upload_encryptor_top.sv
// Multiboot upload encoder, top level: input register, state, output buffer, config.
// Depends on mbenc_pkg and mbenc_crypt.
//
// Takes one image word per beat and gives the words to put on the link. A word
// passes an input register, combinational encoding logic and a two-entry output
// buffer. A word that gives one result is taken every cycle while the output side
// keeps up; the first word of a run (handshake key plus header) and the final word
// (last word plus CRC word) give two results, and the next word waits for room.
// The key multiply on the run state sets the cycle time. Configuration is
// registered, the size through image_bytes_reg and then size_reg and hs_reg.
// The user must write it only while idle; the block itself does not enforce it.
module multiboot_upload_encryptor_top
    import mbenc_pkg::*;
#(
    parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int unsigned SIZE_W = $clog2(MAX_IMAGE_BYTES + 1);

    logic [31:0]       session_key_reg;
    logic [OFFSET_W-1:0] image_bytes_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [31:0]       hs_reg;
    logic [19:0]       size_round;
    logic [19:0]       size_clamp;

    logic              in_vld_reg;
    in_item_t          in_item_reg;
    run_state_t        state_reg;
    run_state_t        state_next;
    beats_t            beats;
    logic              advance;

    out_item_t         slot0_reg;
    out_item_t         slot1_reg;
    logic [1:0]        count_reg;
    logic              pop;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_key_reg <= 32'd0;
            image_bytes_reg <= OFFSET_W'(MIN_SEND_BYTES);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SESSION_KEY: session_key_reg <= cfg_data;
                CFG_IMAGE_BYTES: image_bytes_reg <= cfg_data[OFFSET_W-1:0];
                default:         session_key_reg <= session_key_reg;
            endcase
        end
    end

    // Send size: rounded up to 8 bytes and clamped, then the handshake key.
    always_comb
    begin
        size_round = (20'(image_bytes_reg) + 20'd7) & ~20'd7;
        if (size_round < 20'(MIN_SEND_BYTES))
        begin
            size_clamp = 20'(MIN_SEND_BYTES);
        end
        else if (size_round > 20'(MAX_IMAGE_BYTES))
        begin
            size_clamp = 20'(MAX_IMAGE_BYTES);
        end
        else
        begin
            size_clamp = size_round;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= SIZE_W'(size_clamp);
        hs_reg   <= handshake_word(32'(size_clamp));
    end

    // Input register; it moves on when the output buffer has room for two beats.
    assign advance  = in_vld_reg && ((count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready));
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    mbenc_crypt #(
        .SIZE_W (SIZE_W)
    ) u_crypt (
        .item        (in_item_reg),
        .state       (state_reg),
        .session_key (session_key_reg),
        .send_size   (size_reg),
        .hs_word     (hs_reg),
        .state_next  (state_next),
        .beats       (beats)
    );

    // Run state advances with each encoded word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.crc    <= CRC_INIT;
            state_reg.key    <= 32'd0;
            state_reg.offset <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output buffer: slot 0 is the beat on offer, slot 1 the one behind it.
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (advance)
        begin
            count_reg <= beats.pair ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot0_reg <= beats.first_beat;
            slot1_reg <= beats.second_beat;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// File: rtl/mbenc_checker.sv
// Port-level checker for the multiboot upload encoder, bound to the top level.
// Depends on mbenc_pkg and the assertion macro header.
`include "multiboot_upload_encryptor_top_macros.svh"

module mbenc_checker
    import mbenc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic hs_beat;
    logic crc_beat;

    assign hs_beat  = out_valid && (out_data.word_kind == KIND_HANDSHAKE);
    assign crc_beat = out_valid && (out_data.word_kind == KIND_CRC);

    // A stalled result beat holds its value.
    `MBENC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // The handshake key never closes the results of a word.
    `MBENC_ASSERT_IMP(a_hs_not_last, clk, rst_n, hs_beat, !out_data.end_of_run)

    // The CRC word always closes the results of a word.
    `MBENC_ASSERT_IMP(a_crc_last, clk, rst_n, crc_beat, out_data.end_of_run)

    // The header word follows the handshake key in the very next cycle.
    `MBENC_ASSERT_NXT(a_hs_then_hdr, clk, rst_n, hs_beat && out_ready, out_valid && (out_data.word_kind == KIND_HEADER))

endmodule

bind multiboot_upload_encryptor_top mbenc_checker u_mbenc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/sv/mbenc_link_checker.sv
`timescale 1ns / 100ps
// Checker for the multiboot upload encoder: predicts each link word and compares every output beat.
// Depends on mbenc_pkg for the beat types and constants; the tb module instantiates it beside the block.
module mbenc_link_checker
    import mbenc_pkg::*;
#(
    parameter int unsigned MAX_BYTES = MAX_IMAGE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int unsigned          fail_count,
    output int unsigned          beats_due,
    output int unsigned          beats_checked
);

    // Shadow copies of the registers and of the running encoder state.
    logic [31:0]         session_key;
    logic [OFFSET_W-1:0] image_bytes_reg;
    logic [15:0]         crc_acc;
    logic [31:0]         stream_key;
    logic [OFFSET_W-1:0] byte_offset;

    out_item_t   link_words_due[$];
    int unsigned mismatches;
    int unsigned checked;

    // Image size rounded up to whole 8-byte blocks and held inside the legal window.
    function automatic logic [31:0] padded_size();
        logic [31:0] s;
        s = (32'(image_bytes_reg) + 32'd7) & ~32'd7;
        if (s < MIN_SEND_BYTES)
            s = MIN_SEND_BYTES;
        if (s > MAX_BYTES)
            s = MAX_BYTES;
        return s;
    endfunction

    // Handshake key word derived from the send size.
    function automatic logic [31:0] link_key(logic [31:0] size);
        logic [31:0] blocks;
        logic [31:0] mix;
        logic [31:0] sum;
        logic [31:0] framed;
        blocks = (size - 32'd512) >> 3;
        mix    = ((blocks & 32'h3F80) << 1) | ((blocks & 32'h4000) << 2) | (blocks & 32'h7F)
                 | HS_BASE;
        sum    = (mix >> 8) + (mix >> 16) + mix;
        framed = {sum[7:0], 24'd0} | mix | HS_MARK;
        return framed ^ (framed[9] ? KEY_ALT : KEY_MULT);
    endfunction

    // Reflected CRC, one data bit per step, least significant bit first.
    function automatic logic [15:0] crc_fold(logic [15:0] c, logic [31:0] v);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int b = 0; b < 32; b++)
        begin
            fb = r[0] ^ v[b];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    // Steps the stream key, then masks the word with key, offset term and constant.
    function automatic logic [31:0] scramble(logic [31:0] w, logic [OFFSET_W-1:0] off);
        stream_key = stream_key * KEY_MULT + 32'd1;
        return w ^ stream_key ^ (32'd0 - (32'(off) + OFFSET_BASE)) ^ BODY_XOR;
    endfunction

    function automatic out_item_t make_beat(logic [31:0] w, kind_t kind);
        out_item_t b;
        b.out_word   = w;
        b.word_kind  = kind;
        b.end_of_run = 1'b0;
        return b;
    endfunction

    task automatic restart_run();
        crc_acc     = CRC_INIT;
        stream_key  = '0;
        byte_offset = '0;
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        if (idx == CFG_SESSION_KEY)
            session_key = value;
        else if (idx == CFG_IMAGE_BYTES)
            image_bytes_reg = value[OFFSET_W-1:0];
    endtask

    // Works out the one or two link words that an image word causes.
    task automatic encode_word(in_item_t item);
        out_item_t   beats [0:1];
        int          n;
        logic [31:0] size;
        logic        opens_run;
        n         = 0;
        size      = padded_size();
        opens_run = (byte_offset == '0);
        if (opens_run)
        begin
            stream_key = {session_key[7:0] ^ SESSION_MASK[7:0],
                          session_key[15:8] ^ SESSION_MASK[15:8],
                          session_key[23:16] ^ SESSION_MASK[23:16],
                          session_key[31:24] ^ SESSION_MASK[31:24]};
            crc_acc    = CRC_INIT;
            beats[n]   = make_beat(link_key(size), KIND_HANDSHAKE);
            n++;
        end
        if (byte_offset < HEADER_END)
        begin
            beats[n] = make_beat(item.data_word, KIND_HEADER);
        end
        else
        begin
            crc_acc  = crc_fold(crc_acc, item.data_word);
            beats[n] = make_beat(scramble(item.data_word, byte_offset), KIND_BODY);
        end
        n++;
        byte_offset = byte_offset + WORD_BYTES;
        if (item.is_final_word)
        begin
            // The size lands in the upper half, so only its low 16 bits survive.
            if (!opens_run)
            begin
                beats[n] = make_beat(scramble({size[15:0], crc_acc}, byte_offset), KIND_CRC);
                n++;
            end
            restart_run();
        end
        beats[n-1].end_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            link_words_due.push_back(beats[i]);
    endtask

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: link word mismatch on %s: expected %h, got %h",
                     $time, what, want, got);
    endtask

    task automatic check_beat(out_item_t got);
        out_item_t want;
        if (link_words_due.size() == 0)
        begin
            note_mismatch("a beat with nothing due", 32'd0, got.out_word);
        end
        else
        begin
            want = link_words_due.pop_front();
            if (got.out_word !== want.out_word)
                note_mismatch("out_word", want.out_word, got.out_word);
            if (got.word_kind !== want.word_kind)
                note_mismatch("word_kind", 32'(want.word_kind), 32'(got.word_kind));
            if (got.end_of_run !== want.end_of_run)
                note_mismatch("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
        end
        checked++;
    endtask

    // Sample all three channels at the clock edge and pass the counters to the top as registered outputs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_key     = '0;
            image_bytes_reg = 19'd512;
            restart_run();
            link_words_due.delete();
            mismatches      = 0;
            checked         = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                encode_word(in_data);
            if (out_valid && out_ready)
                check_beat(out_data);
        end
        fail_count    <= mismatches;
        beats_due     <= link_words_due.size();
        beats_checked <= checked;
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the multiboot upload encoder testbench: clock, reset, stimulus, idling and verdict.
// Depends on mbenc_pkg, multiboot_upload_encryptor_top and mbenc_link_checker.
module tb;
    import mbenc_pkg::*;

    localparam int unsigned IMAGE_LIMIT  = MAX_IMAGE_BYTES_DEF;
    localparam int unsigned PHASE_WORDS  = 500;
    localparam int unsigned SETTLE_TICKS = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SESSION_KEY;
    logic [31:0]          cfg_data  = '0;

    int unsigned fail_count;
    int unsigned beats_due;
    int unsigned beats_checked;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned words_sent    = 0;
    int unsigned runs_closed   = 0;
    int unsigned settings_used = 0;

    multiboot_upload_encryptor_top #(
        .MAX_IMAGE_BYTES(IMAGE_LIMIT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    mbenc_link_checker #(
        .MAX_BYTES(IMAGE_LIMIT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .beats_due    (beats_due),
        .beats_checked(beats_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver side: random back-pressure at the rate of the current phase.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Image sizes around the clamps and the rounding, plus random ones in and out of range.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd512;
            2:       return 32'h7FFFF;
            3:       return IMAGE_LIMIT;
            4:       return IMAGE_LIMIT - 7;
            5:       return $urandom_range(511, 1);
            6:       return $urandom_range(32'h7FFFF, 0);
            default: return $urandom_range(IMAGE_LIMIT, 512);
        endcase
    endfunction

    // One image word; valid drops only when an idle gap comes before the beat.
    task automatic send_word(logic [31:0] w, logic fin);
        in_item_t beat;
        beat.data_word     = w;
        beat.is_final_word = fin;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (fin)
            runs_closed++;
    endtask

    // Stop sending and wait until every predicted link word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(logic [31:0] key, logic [31:0] bytes);
        write_reg(CFG_SESSION_KEY, key);
        write_reg(CFG_IMAGE_BYTES, bytes);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly whole runs that reach the body; some stop inside the header, some are noise.
    task automatic send_random_run();
        int shape;
        int words;
        shape = $urandom_range(99);
        if (shape < 10)
        begin
            repeat ($urandom_range(8, 1)) send_word(pick_word(), 1'($urandom_range(1)));
        end
        else
        begin
            if (shape < 25)
                words = $urandom_range(48, 1);
            else if (shape < 95)
                words = $urandom_range(120, 49);
            else
                words = $urandom_range(400, 200);
            for (int i = 0; i < words; i++)
                send_word(pick_word(), i == words - 1);
        end
    endtask

    initial
    begin
        int unsigned phase_start;
        bit          paused;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a run that is only its first word, and a final mark inside the header.
        configure(32'h0000_0000, 32'd512);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        drain();

        // Directed: size clamped from above, so the CRC word loses its size half.
        configure(32'hFFFF_FFFF, 32'h7FFFF);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        drain();

        // Directed: size clamped from below, then sizes that need rounding.
        configure($urandom(), 32'd0);
        send_word(32'hA5A5_A5A5, 1'b0);
        send_word(32'h5A5A_5A5A, 1'b1);
        drain();
        configure($urandom(), 32'd513);
        send_word($urandom(), 1'b1);
        drain();
        configure($urandom(), IMAGE_LIMIT - 1);
        send_word($urandom(), 1'b0);
        send_word($urandom(), 1'b1);
        drain();

        // Random phases: none, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 83;
                end
                default:
                begin
                    send_idle_pct = 21;
                    stall_pct    <= 21;
                end
            endcase
            configure(pick_key(), pick_size());
            phase_start = words_sent;
            paused      = 1'b0;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                // Halfway through, hold off until the output side has caught up.
                if (!paused && words_sent - phase_start >= PHASE_WORDS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                send_random_run();
            end
            drain();
        end

        $display("Sent %0d image words in %0d closed runs under %0d register settings,",
                 words_sent, runs_closed, settings_used);
        $display("including clamped sizes, header-only runs and stalls; %0d link words checked.",
                 beats_checked);
        if (fail_count == 0 && beats_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(64'd8_000_000);
        $display("Watchdog expired with %0d link words still due.", beats_due);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
